// ===== rtl/bdr_pkg.sv =====
// Package for the banked DMA RAM device: item kinds, register map constants
// and the per-item result control carried between the decode and the output stage.
// No dependencies.
`default_nettype none

package bdr_pkg;

  typedef enum logic [1:0] {
    KIND_REG_RD = 2'd0,
    KIND_REG_WR = 2'd1,
    KIND_DMA_RD = 2'd2,
    KIND_DMA_WR = 2'd3
  } kind_t;

  localparam int unsigned REG_W      = 21;
  localparam int unsigned PAGE_SHIFT = 11;
  localparam int unsigned BANK_SHIFT = 21;

  localparam logic [REG_W-1:0] STATUS_LIMIT      = 21'h00020;
  localparam logic [REG_W-1:0] SIZE_WINDOW_START = 21'h20000;
  localparam logic [REG_W-1:0] PTR_WINDOW_END    = 21'h80000;
  localparam logic [REG_W-1:0] PAGE_OFS_MASK     = 21'h007FC;
  localparam logic [15:0]      STATUS_VALUE      = 16'h0050;

  // What the output stage must do with an item once the RAM has answered
  typedef struct packed {
    logic status;   // register read of the status area
    logic reg_ram;  // register read served from RAM
    logic dma_rd;   // DMA read byte served from RAM
    logic oor;      // RAM access beyond the array, dropped
    logic done;     // end of DMA transfer
  } res_meta_t;

endpackage

`default_nettype wire

// ===== rtl/bdr_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Read data updates only on a read access and holds otherwise. No dependencies.
`default_nettype none

module bdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/bdr_ctrl.sv =====
// Item decode and per-bank DMA pointer file: turns an accepted item into at most one
// RAM access plus result control. Depends on bdr_pkg.
`default_nettype none

module bdr_ctrl
  import bdr_pkg::*;
#(
  parameter int RAM_BYTES          = 1048576,
  parameter int BANK_BYTES         = 262144,
  parameter int NUM_BANKS          = 4,
  parameter int REG_MASK           = 2097151,
  parameter int READ_WINDOW_START  = 262144,
  parameter int WRITE_WINDOW_START = 393216
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [1:0]                   kind,
  input  wire logic [22:0]                  offset,
  input  wire logic [15:0]                  write_value,
  input  wire logic [1:0]                   bank,
  input  wire logic [7:0]                   dma_byte_in,
  input  wire logic                         transfer_last,
  output logic                              ram_en,
  output logic                              ram_we,
  output logic [$clog2(RAM_BYTES)-1:0]      ram_addr,
  output logic [7:0]                        ram_wdata,
  output res_meta_t                         meta
);

  localparam int AW = $clog2(RAM_BYTES);
  localparam int BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam logic [24:0] RAM_LIMIT = 25'(RAM_BYTES);

  function automatic logic [BW-1:0] pick_bank(input logic [1:0] v);
    logic [2:0] m;
    m = {1'b0, v} & 3'(NUM_BANKS - 1);
    return BW'(m);
  endfunction

  logic [AW-1:0] rd_ptr_r [NUM_BANKS];
  logic [AW-1:0] wr_ptr_r [NUM_BANKS];

  logic [REG_W-1:0] reg_ofs;
  logic [21:0]      ram_off;
  logic             ram_ok;
  logic [BW-1:0]    rbank;
  logic [BW-1:0]    dbank;
  logic [AW-1:0]    bank_start;
  logic [AW-1:0]    target;
  logic             in_rd_win;
  logic             in_wr_win;
  logic             in_size_win;

  logic             en;
  logic             rp_we;
  logic             wp_we;
  logic [BW-1:0]    rp_idx;
  logic [BW-1:0]    wp_idx;
  logic [AW-1:0]    rp_nxt;
  logic [AW-1:0]    wp_nxt;

  assign reg_ofs    = offset[REG_W-1:0] & REG_W'(REG_MASK);
  assign ram_off    = offset[22:1];
  assign ram_ok     = {3'b000, ram_off} < RAM_LIMIT;
  assign rbank      = pick_bank(offset[22:BANK_SHIFT]);
  assign dbank      = pick_bank(bank);
  assign bank_start = AW'(32'(rbank) * 32'(BANK_BYTES));
  // Wraps modulo the RAM size through the address width
  assign target     = bank_start + AW'({write_value, 11'b0})
                    + AW'(reg_ofs & PAGE_OFS_MASK);

  assign in_rd_win   = (reg_ofs >= REG_W'(READ_WINDOW_START)) &&
                       (reg_ofs <  REG_W'(WRITE_WINDOW_START));
  assign in_wr_win   = (reg_ofs >= REG_W'(WRITE_WINDOW_START)) &&
                       (reg_ofs <  PTR_WINDOW_END);
  assign in_size_win = (reg_ofs >= SIZE_WINDOW_START) &&
                       (reg_ofs <  REG_W'(READ_WINDOW_START));

  always_comb begin
    en        = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(ram_off);
    ram_wdata = write_value[7:0];
    meta      = '0;
    rp_we     = 1'b0;
    wp_we     = 1'b0;
    rp_idx    = rbank;
    wp_idx    = rbank;
    rp_nxt    = target;
    wp_nxt    = target;
    case (kind_t'(kind))
      KIND_REG_RD: begin
        if (reg_ofs < STATUS_LIMIT) begin
          meta.status = 1'b1;
        end else if (ram_ok) begin
          en           = 1'b1;
          meta.reg_ram = 1'b1;
        end else begin
          meta.oor = 1'b1;
        end
      end
      KIND_REG_WR: begin
        if (in_rd_win) begin
          rp_we = 1'b1;
        end else if (in_wr_win) begin
          wp_we = 1'b1;
        end else if (in_size_win) begin
          // size window: drop the write
        end else if (ram_ok) begin
          en     = 1'b1;
          ram_we = 1'b1;
        end else begin
          meta.oor = 1'b1;
        end
      end
      KIND_DMA_RD: begin
        en          = 1'b1;
        ram_addr    = rd_ptr_r[dbank];
        meta.dma_rd = 1'b1;
        meta.done   = transfer_last;
        rp_we       = 1'b1;
        rp_idx      = dbank;
        rp_nxt      = rd_ptr_r[dbank] + AW'(1);
      end
      KIND_DMA_WR: begin
        en        = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = wr_ptr_r[dbank];
        ram_wdata = dma_byte_in;
        meta.done = transfer_last;
        wp_we     = 1'b1;
        wp_idx    = dbank;
        wp_nxt    = wr_ptr_r[dbank] + AW'(1);
      end
      default: begin
      end
    endcase
  end

  assign ram_en = accept & en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
      end
    end else if (accept) begin
      if (rp_we) begin
        rd_ptr_r[rp_idx] <= rp_nxt;
      end
      if (wp_we) begin
        wr_ptr_r[wp_idx] <= wp_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/banked_dma_ram_device_unit.sv =====
// Banked DMA RAM device: byte RAM behind a 16-bit register window with per-bank
// DMA read and write pointers. Depends on bdr_pkg, bdr_ctrl and bdr_ram.
//
// Each input transfer is one item: a register read, a register write, a DMA read
// byte or a DMA write byte, selected by in_tuser. Every item yields exactly one
// output transfer. The block takes one item per clock while in_tready is high;
// the item's RAM access, if any, goes to the one port of the byte RAM at the
// accepting edge while its result control is staged, and the RAM's registered
// read data is folded into the output register when the staged item advances,
// which raises out_tvalid. Because every item touches the RAM at most once
// and the pointers update at acceptance, a following item always sees the
// previous one's write, so no interlock is needed. Backpressure on out_tready
// holds the output register and the in-flight item, and in_tready drops only
// when both are full. The RAM content is not cleared by reset; reading a byte
// never written returns an undefined value. Pointers reset to zero and wrap
// modulo RAM_BYTES, which must be a power of two.
`default_nettype none

module banked_dma_ram_device_unit
  import bdr_pkg::*;
#(
  parameter int RAM_BYTES          = 1048576,
  parameter int BANK_BYTES         = 262144,
  parameter int NUM_BANKS          = 4,
  parameter int REG_MASK           = 2097151,
  parameter int READ_WINDOW_START  = 262144,
  parameter int WRITE_WINDOW_START = 393216
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [22:0] offset, [38:23] write_value, [40:39] bank, [48:41] dma_byte_in,
  // [55:49] zero
  input  wire logic [55:0] in_tdata,
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  input  wire logic        in_tlast,   // transfer_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [15:0] read_data, [23:16] dma_byte_out
  output logic             out_tuser,  // [0] out_of_range
  output logic             out_tlast   // transfer_done
);

  localparam int AW = $clog2(RAM_BYTES);

  // Accept and advance
  logic      accept;
  logic      s1_adv;

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  res_meta_t s1_meta_r;

  logic      out_valid_r;
  logic      out_valid_nxt;
  logic [15:0] out_rdata_r;
  logic [15:0] out_rdata_nxt;
  logic [7:0]  out_dbyte_r;
  logic [7:0]  out_dbyte_nxt;
  logic        out_oor_r;
  logic        out_done_r;

  // RAM port
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  res_meta_t     dec_meta;

  // Move the staged item out when the output register is free or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  bdr_ctrl #(
    .RAM_BYTES          (RAM_BYTES),
    .BANK_BYTES         (BANK_BYTES),
    .NUM_BANKS          (NUM_BANKS),
    .REG_MASK           (REG_MASK),
    .READ_WINDOW_START  (READ_WINDOW_START),
    .WRITE_WINDOW_START (WRITE_WINDOW_START)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .kind          (in_tuser),
    .offset        (in_tdata[22:0]),
    .write_value   (in_tdata[38:23]),
    .bank          (in_tdata[40:39]),
    .dma_byte_in   (in_tdata[48:41]),
    .transfer_last (in_tlast),
    .ram_en        (ram_en),
    .ram_we        (ram_we),
    .ram_addr      (ram_addr),
    .ram_wdata     (ram_wdata),
    .meta          (dec_meta)
  );

  // Read data holds while the staged item waits, since no access is issued then
  bdr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Fold the RAM answer into the result fields
    out_rdata_nxt = '0;
    if (s1_meta_r.status) begin
      out_rdata_nxt = STATUS_VALUE;
    end else if (s1_meta_r.reg_ram) begin
      out_rdata_nxt = {8'h00, ram_rdata};
    end
    out_dbyte_nxt = s1_meta_r.dma_rd ? ram_rdata : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on transfer into each stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= dec_meta;
    end
    if (s1_adv) begin
      out_rdata_r <= out_rdata_nxt;
      out_dbyte_r <= out_dbyte_nxt;
      out_oor_r   <= s1_meta_r.oor;
      out_done_r  <= s1_meta_r.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dbyte_r, out_rdata_r};
  assign out_tuser  = out_oor_r;
  assign out_tlast  = out_done_r;

endmodule

`default_nettype wire

// ===== tb/sv/banked_dma_ram_device_unit_tb.sv =====
// Self-checking testbench for banked_dma_ram_device_unit: register window and DMA
// byte traffic against a cycle-free predictor, with random stalls on both streams.
// Depends on bdr_pkg and the banked_dma_ram_device_unit RTL.
`timescale 1ns / 100ps

module banked_dma_ram_device_unit_tb;
  import bdr_pkg::*;

  localparam int RAM_BYTES          = 1048576;
  localparam int BANK_BYTES         = 262144;
  localparam int NUM_BANKS          = 4;
  localparam int REG_MASK           = 2097151;
  localparam int READ_WINDOW_START  = 262144;
  localparam int WRITE_WINDOW_START = 393216;
  localparam int ADDR_W             = $clog2(RAM_BYTES);

  localparam int RANDOM_ITEMS = 1750;
  localparam int TAIL_ITEMS   = 150;   // no idling on either side for the last ones
  localparam int DRAIN_AT     = 900;   // sender waits here until every result is back
  localparam int HOLD_AT      = 400;   // receiver blocks after this many results
  localparam int HOLD_CYCLES  = 150;

  // One access as the sender sees it
  typedef struct {
    kind_t       kind;
    logic [22:0] offset;
    logic [15:0] wvalue;
    logic [1:0]  bank;
    logic [7:0]  din;
    logic        last;
  } dev_item_t;

  // One result transfer
  typedef struct {
    logic [15:0] rd_data;
    logic [7:0]  dma_out;
    logic        oor;
    logic        done;
  } dev_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = KIND_REG_RD;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // Stimulus and scoreboard
  dev_item_t   item_q[$];
  dev_result_t predicted_q[$];
  int          total_items  = 0;
  int          acc_cnt      = 0;   // driver-private count of accepted items
  int          items_done   = 0;   // published copy, updated at the edge
  int          results_seen = 0;
  int          mismatch_cnt = 0;

  // Predictor state, touched by the driver only
  logic [7:0]        ram_img [int];
  logic [ADDR_W-1:0] rd_ptr [NUM_BANKS] = '{default: '0};
  logic [ADDR_W-1:0] wr_ptr [NUM_BANKS] = '{default: '0};

  // Planning view used while building stimulus: which bytes hold data and where
  // the pointers will stand, so no read ever lands on a byte never written
  bit                plan_written [int];
  int unsigned       plan_addrs[$];
  logic [ADDR_W-1:0] plan_rd [NUM_BANKS] = '{default: '0};
  logic [ADDR_W-1:0] plan_wr [NUM_BANKS] = '{default: '0};

  // Driver and monitor pacing
  dev_item_t   tx_item;
  int          tx_idle  = 0;
  bit          tx_calm  = 1'b0;
  int          rx_idle  = 0;
  bit          rx_calm  = 1'b0;
  int          hold_cnt = 0;
  bit          hold_armed = 1'b1;
  dev_result_t want_r;
  dev_result_t got_r;

  always #4 clk = ~clk;

  banked_dma_ram_device_unit #(
    .RAM_BYTES         (RAM_BYTES),
    .BANK_BYTES        (BANK_BYTES),
    .NUM_BANKS         (NUM_BANKS),
    .REG_MASK          (REG_MASK),
    .READ_WINDOW_START (READ_WINDOW_START),
    .WRITE_WINDOW_START(WRITE_WINDOW_START)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Work out the result of one accepted item and advance the RAM image and pointers
  function automatic dev_result_t predict_access(dev_item_t it);
    dev_result_t      r;
    logic [REG_W-1:0] reg_ofs;
    int unsigned      ram_addr;
    int unsigned      sel;
    int unsigned      target;
    r        = '{default: '0};
    reg_ofs  = REG_W'(it.offset & REG_MASK);
    ram_addr = 32'(it.offset >> 1);
    sel      = (it.offset >> BANK_SHIFT) & (NUM_BANKS - 1);
    case (it.kind)
      KIND_REG_RD: begin
        if (reg_ofs < STATUS_LIMIT) begin
          r.rd_data = STATUS_VALUE;
        end else if (ram_addr < RAM_BYTES) begin
          r.rd_data = {8'h00, ram_img[ram_addr]};
        end else begin
          r.oor = 1'b1;
        end
      end
      KIND_REG_WR: begin
        target = (sel * BANK_BYTES + (32'(it.wvalue) << PAGE_SHIFT)
                 + 32'(reg_ofs & PAGE_OFS_MASK)) & (RAM_BYTES - 1);
        if (reg_ofs >= READ_WINDOW_START && reg_ofs < WRITE_WINDOW_START) begin
          rd_ptr[sel] = ADDR_W'(target);
        end else if (reg_ofs >= WRITE_WINDOW_START && reg_ofs < PTR_WINDOW_END) begin
          wr_ptr[sel] = ADDR_W'(target);
        end else if (reg_ofs >= SIZE_WINDOW_START && reg_ofs < READ_WINDOW_START) begin
          // size window: drop the write
        end else if (ram_addr < RAM_BYTES) begin
          ram_img[ram_addr] = it.wvalue[7:0];
        end else begin
          r.oor = 1'b1;
        end
      end
      KIND_DMA_RD: begin
        r.dma_out         = ram_img[rd_ptr[it.bank]];
        rd_ptr[it.bank]   = rd_ptr[it.bank] + 1'b1;   // wraps with the pointer width
        r.done            = it.last;
      end
      default: begin
        ram_img[wr_ptr[it.bank]] = it.din;
        wr_ptr[it.bank]          = wr_ptr[it.bank] + 1'b1;
        r.done                   = it.last;
      end
    endcase
    return r;
  endfunction

  // Every field random, so unused bits toggle too; callers override what matters
  function automatic dev_item_t random_item(kind_t k);
    dev_item_t it;
    it.kind   = k;
    it.offset = 23'($urandom);
    it.wvalue = 16'($urandom);
    it.bank   = 2'($urandom);
    it.din    = 8'($urandom);
    it.last   = 1'($urandom);
    return it;
  endfunction

  // Queue an item and keep the planning view in step with it. Pointer window
  // writes come only from set_pointer, which updates the plan itself.
  task automatic queue_item(dev_item_t it);
    logic [REG_W-1:0] reg_ofs;
    int               addr;
    reg_ofs = REG_W'(it.offset & REG_MASK);
    addr    = -1;
    case (it.kind)
      KIND_REG_WR: begin
        if (!(reg_ofs >= SIZE_WINDOW_START && reg_ofs < PTR_WINDOW_END)
            && (it.offset >> 1) < RAM_BYTES)
          addr = 32'(it.offset >> 1);
      end
      KIND_DMA_WR: begin
        addr             = 32'(plan_wr[it.bank]);
        plan_wr[it.bank] = plan_wr[it.bank] + 1'b1;
      end
      KIND_DMA_RD: plan_rd[it.bank] = plan_rd[it.bank] + 1'b1;
      default: ;
    endcase
    if (addr >= 0 && !plan_written.exists(addr)) begin
      plan_written[addr] = 1'b1;
      plan_addrs.push_back(addr);
    end
    item_q.push_back(it);
  endtask

  // Aim a bank's DMA pointer at a word-aligned address through its register window;
  // the page comes from the value, the word within the page from the offset
  task automatic set_pointer(bit to_wr, logic [1:0] b, logic [ADDR_W-1:0] s);
    dev_item_t         it;
    logic [ADDR_W-1:0] rel;
    logic [REG_W-1:0]  base;
    s[1:0] = 2'b00;
    it     = random_item(KIND_REG_WR);
    rel    = s - ADDR_W'(b * BANK_BYTES);
    base   = REG_W'(to_wr ? WRITE_WINDOW_START : READ_WINDOW_START);
    it.wvalue[ADDR_W-PAGE_SHIFT-1:0] = rel[ADDR_W-1:PAGE_SHIFT];
    it.offset[22:21] = b;
    it.offset[20:17] = base[20:17];
    it.offset[10:2]  = s[10:2];
    if (to_wr) plan_wr[b] = s;
    else plan_rd[b] = s;
    queue_item(it);
  endtask

  task automatic reg_store(int unsigned addr);
    dev_item_t it;
    it              = random_item(KIND_REG_WR);
    it.offset[22:1] = 22'(addr);
    queue_item(it);
  endtask

  task automatic reg_load(int unsigned addr);
    dev_item_t it;
    it              = random_item(KIND_REG_RD);
    it.offset[22:1] = 22'(addr);
    queue_item(it);
  endtask

  task automatic dma_move(kind_t k, logic [1:0] b, logic last);
    dev_item_t it;
    it      = random_item(k);
    it.bank = b;
    it.last = last;
    queue_item(it);
  endtask

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    mismatch_cnt++;
    $display("result %0d: %s is 0x%0h, predicted 0x%0h", results_seen, field, got, want);
  endtask

  // Driver: present the next pending item whenever the slot is free, predict on
  // every accepted transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_q.push_back(predict_access(tx_item));
        acc_cnt++;
        items_done <= acc_cnt;
      end
      if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
      if (tx_idle != 0) tx_idle--;
      if (!in_tvalid || in_tready) begin
        // start an idle burst only between transfers, never while the receiver
        // is held off, so the block fills up then
        if (tx_idle == 0 && !tx_calm && hold_cnt == 0
            && acc_cnt < total_items - TAIL_ITEMS && $urandom_range(0, 7) == 0)
          tx_idle = $urandom_range(1, 19);
        if (item_q.size() != 0 && tx_idle == 0
            && !(acc_cnt == DRAIN_AT && results_seen != DRAIN_AT)) begin
          tx_item   = item_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'b0, tx_item.din, tx_item.bank, tx_item.wvalue, tx_item.offset};
          in_tuser  <= tx_item.kind;
          in_tlast  <= tx_item.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver block, counted here so the monitor just sees a flag
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt   <= 0;
      hold_armed <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_armed && results_seen >= HOLD_AT) begin
      hold_cnt   <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end
  end

  // Monitor: compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got_r.rd_data = out_tdata[15:0];
        got_r.dma_out = out_tdata[23:16];
        got_r.oor     = out_tuser;
        got_r.done    = out_tlast;
        if (predicted_q.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(out_tdata), 0);
        end else begin
          want_r = predicted_q.pop_front();
          if (got_r.rd_data !== want_r.rd_data)
            report_mismatch("read_data", 32'(got_r.rd_data), 32'(want_r.rd_data));
          if (got_r.dma_out !== want_r.dma_out)
            report_mismatch("dma_byte_out", 32'(got_r.dma_out), 32'(want_r.dma_out));
          if (got_r.oor !== want_r.oor)
            report_mismatch("out_of_range", 32'(got_r.oor), 32'(want_r.oor));
          if (got_r.done !== want_r.done)
            report_mismatch("transfer_done", 32'(got_r.done), 32'(want_r.done));
        end
      end
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (rx_idle != 0) rx_idle--;
      else if (!rx_calm && results_seen < total_items - TAIL_ITEMS
               && $urandom_range(0, 7) == 0)
        rx_idle = $urandom_range(1, 19);
      out_tready <= (rx_idle == 0) && (hold_cnt == 0);
    end
  end

  // Build the stimulus, release reset, wait for every result, then judge
  initial begin
    dev_item_t         it;
    logic [ADDR_W-1:0] s;
    logic [1:0]        b;
    int                n;
    int                m;
    int                i;
    int                pick;
    int                n_directed;

    // Status area, including with bank bits set
    it = random_item(KIND_REG_RD); it.offset = 23'h000000; queue_item(it);
    it = random_item(KIND_REG_RD); it.offset = 23'h00001F; queue_item(it);
    it = random_item(KIND_REG_RD); it.offset = 23'h600010; queue_item(it);
    // Read and write beyond the RAM
    it = random_item(KIND_REG_RD); it.offset = 23'h7FFFFF; queue_item(it);
    it = random_item(KIND_REG_WR); it.offset = 23'h7FFFFF; it.wvalue = 16'hFFFF;
    queue_item(it);
    // Plain RAM writes, one inside the status offsets
    it = random_item(KIND_REG_WR); it.offset = 23'h000000; it.wvalue = 16'h00A5;
    queue_item(it);
    it = random_item(KIND_REG_WR); it.offset = 23'h000021; it.wvalue = 16'hFFFF;
    queue_item(it);
    // Size window edges: dropped; then reads of the byte at offsets 0x21 and 0x20
    it = random_item(KIND_REG_WR); it.offset = 23'h020000; queue_item(it);
    it = random_item(KIND_REG_WR); it.offset = 23'h03FFFF; queue_item(it);
    it = random_item(KIND_REG_RD); it.offset = 23'h000021; queue_item(it);
    it = random_item(KIND_REG_RD); it.offset = 23'h000020; queue_item(it);
    // DMA write across the top of the RAM on the last bank, then read it back
    set_pointer(1'b1, 2'd3, ADDR_W'(RAM_BYTES - 4));
    for (i = 0; i < 5; i++) begin
      it = random_item(KIND_DMA_WR);
      it.bank = 2'd3;
      it.last = (i == 4);
      if (i == 0) it.din = 8'hFF;
      if (i == 1) it.din = 8'h00;
      queue_item(it);
    end
    set_pointer(1'b0, 2'd3, ADDR_W'(RAM_BYTES - 4));
    for (i = 0; i < 5; i++) dma_move(KIND_DMA_RD, 2'd3, i == 4);
    it = random_item(KIND_REG_RD); it.offset = 23'h1FFFFF; queue_item(it);
    n_directed = item_q.size();

    while (item_q.size() < n_directed + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      b    = 2'($urandom);
      if (pick < 45) begin
        // DMA transfer: aim, stream bytes in, often stream them back out
        if ($urandom_range(0, 6) == 0) s = ADDR_W'(RAM_BYTES - 16 + 4 * $urandom_range(0, 3));
        else s = ADDR_W'($urandom);
        n = $urandom_range(1, 12);
        set_pointer(1'b1, b, s);
        for (i = 0; i < n; i++) dma_move(KIND_DMA_WR, b, i == n - 1);
        if ($urandom_range(0, 9) < 7) begin
          b = 2'($urandom);
          m = $urandom_range(1, n);
          set_pointer(1'b0, b, s);
          for (i = 0; i < m; i++) dma_move(KIND_DMA_RD, b, i == m - 1);
        end
      end else if (pick < 65) begin
        // Register stores below the size window or above the pointer windows,
        // then loads of bytes that hold data
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 1) == 0)
            reg_store($urandom_range(0, (SIZE_WINDOW_START >> 1) - 1));
          else
            reg_store($urandom_range(PTR_WINDOW_END >> 1, RAM_BYTES - 1));
        end
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
          reg_load(plan_addrs[$urandom_range(0, plan_addrs.size() - 1)]);
      end else if (pick < 80) begin
        // Noise: status reads, out-of-range accesses, size window writes
        case ($urandom_range(0, 3))
          0: begin
            it = random_item(KIND_REG_RD);
            it.offset[20:5] = '0;
          end
          1: begin
            it = random_item(KIND_REG_RD);
            it.offset[22:21] = 2'($urandom_range(1, 3));
            if (it.offset[20:5] == '0) it.offset[5] = 1'b1;
          end
          2: begin
            it = random_item(KIND_REG_WR);
            it.offset[22:21] = 2'($urandom_range(1, 3));
            if (it.offset[20:19] == 2'b00 && it.offset[18:17] != 2'b00) it.offset[20] = 1'b1;
          end
          default: begin
            it = random_item(KIND_REG_WR);
            it.offset[20:17] = 4'b0001;
          end
        endcase
        queue_item(it);
      end else if (pick < 90) begin
        // Continue a stream: read only where the byte holds data, else write
        if (plan_written.exists(plan_rd[b])) dma_move(KIND_DMA_RD, b, 1'($urandom));
        else dma_move(KIND_DMA_WR, b, 1'($urandom));
      end else begin
        set_pointer(1'($urandom), b, ADDR_W'($urandom));
      end
    end
    total_items = item_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (items_done != total_items || results_seen != total_items) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bdr_pkg.sv
rtl/bdr_ram.sv
rtl/bdr_ctrl.sv
rtl/banked_dma_ram_device_unit.sv
tb/sv/banked_dma_ram_device_unit_tb.sv
